[rtl/perspective_divide_viewport_macros.svh]
// Assertion macros used by the perspective divide and viewport top module.
`ifndef PERSPECTIVE_DIVIDE_VIEWPORT_MACROS_SVH
`define PERSPECTIVE_DIVIDE_VIEWPORT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PDV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdv assertion failed");

// Condition that must hold on the edge after a reset cycle.
`define PDV_ASSERT_AFTER_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("pdv reset assertion failed");

`endif

[rtl/pdv_pkg.sv]
// Package: widths, register indexes, beat types and helpers for the divide/viewport block.
`timescale 1ns / 1ps
package pdv_pkg;

  localparam int CW        = 32;          // coordinate width
  localparam int FB        = 16;          // fraction bits
  localparam int QW        = CW + FB;     // quotient bits produced by the divider
  localparam int SIZE_W    = 14;          // viewport size register width
  localparam int PW        = CW + SIZE_W + 2;  // viewport product width
  localparam int DIV_LAT   = QW + 1;      // divider steps plus clamp register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] VP_WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] VP_HEIGHT_RST = SIZE_W'(480);

  // 1.0 in Q format, one bit wider than a coordinate
  localparam logic signed [CW:0] ONEQ = (CW+1)'(1) << FB;

  typedef struct packed {
    logic signed [CW-1:0] clip_x;
    logic signed [CW-1:0] clip_y;
    logic signed [CW-1:0] clip_z;
    logic signed [CW-1:0] clip_w;
  } vtx_t;

  typedef struct packed {
    logic signed [CW-1:0] screen_x;
    logic signed [CW-1:0] screen_y;
    logic signed [CW-1:0] depth_z;
    logic signed [CW-1:0] w_out;
    logic                 w_was_zero;
    logic                 saturated;
  } pix_t;

  // Merged lane results handed to the viewport stage
  typedef struct packed {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic signed [CW-1:0] nz;
    logic signed [CW-1:0] w;
    logic                 wz;
    logic                 sat;
  } ndc_t;

  typedef struct packed {
    logic signed [CW-1:0] val;
    logic                 sat;
  } clamp_t;

  // Magnitude of a signed coordinate; the most negative value fits unsigned
  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    mag = v[CW-1] ? (~v + CW'(1)) : v;
  endfunction

  // Halve toward zero, then clamp into the coordinate range
  function automatic clamp_t half_clamp(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] h;
    logic signed [PW-1:0] maxv;
    logic signed [PW-1:0] minv;
    clamp_t res;
    h    = p[PW-1] ? ((p + PW'(1)) >>> 1) : (p >>> 1);
    maxv = PW'((CW+1)'(2 ** (CW - 1) - 1));
    minv = -maxv - PW'(1);
    res.sat = 1'b0;
    if (h > maxv) begin
      res.val = maxv[CW-1:0];
      res.sat = 1'b1;
    end else if (h < minv) begin
      res.val = minv[CW-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = h[CW-1:0];
    end
    half_clamp = res;
  endfunction

endpackage

[rtl/pdv_div_lane.sv]
// One divider lane: pipelined restoring division (a << FB) / d with saturating clamp.
`timescale 1ns / 1ps
module pdv_div_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pdv_pkg::CW-1:0]        mag_a,
  input  logic [pdv_pkg::CW-1:0]        mag_d,
  input  logic                          neg,
  output logic signed [pdv_pkg::CW-1:0] quot,
  output logic                          sat
);

  // Per-step registers, index k holds the state after step k
  logic [pdv_pkg::CW-1:0] rem [0:pdv_pkg::QW-1];
  logic [pdv_pkg::QW-1:0] num [0:pdv_pkg::QW-1];
  logic [pdv_pkg::QW-1:0] quo [0:pdv_pkg::QW-1];
  logic [pdv_pkg::CW-1:0] dv  [0:pdv_pkg::QW-1];
  logic                   ng  [0:pdv_pkg::QW-1];

  // One quotient bit per stage
  for (genvar k = 0; k < pdv_pkg::QW; k++) begin : g_step
    logic [pdv_pkg::CW-1:0] r_in;
    logic [pdv_pkg::QW-1:0] n_in;
    logic [pdv_pkg::QW-1:0] q_in;
    logic [pdv_pkg::CW-1:0] d_in;
    logic                   s_in;
    logic [pdv_pkg::CW:0]   trial;
    logic                   ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = {mag_a, {pdv_pkg::FB{1'b0}}};
      assign q_in = '0;
      assign d_in = mag_d;
      assign s_in = neg;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign n_in = num[k-1];
      assign q_in = quo[k-1];
      assign d_in = dv[k-1];
      assign s_in = ng[k-1];
    end

    assign trial = {r_in, n_in[pdv_pkg::QW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? pdv_pkg::CW'(trial - {1'b0, d_in}) : trial[pdv_pkg::CW-1:0];
        num[k] <= n_in << 1;
        quo[k] <= {q_in[pdv_pkg::QW-2:0], ge};
        dv[k]  <= d_in;
        ng[k]  <= s_in;
      end
    end
  end

  // Clamp magnitude to the signed range and apply sign
  logic [pdv_pkg::QW-1:0] q_fin;
  logic [pdv_pkg::QW-1:0] lim;
  logic [pdv_pkg::QW-1:0] q_cl;
  logic                   over;

  assign q_fin = quo[pdv_pkg::QW-1];
  assign lim   = ng[pdv_pkg::QW-1] ? (pdv_pkg::QW'(1) << (pdv_pkg::CW - 1))
                                   : ((pdv_pkg::QW'(1) << (pdv_pkg::CW - 1)) - pdv_pkg::QW'(1));
  assign over  = q_fin > lim;
  assign q_cl  = over ? lim : q_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= ng[pdv_pkg::QW-1] ? -q_cl[pdv_pkg::CW-1:0] : q_cl[pdv_pkg::CW-1:0];
      sat  <= over;
    end
  end

endmodule

[rtl/pdv_viewport.sv]
// Viewport stage: takes merged lane quotients, scales by viewport size, halves and clamps.
`timescale 1ns / 1ps
module pdv_viewport (
  input  logic                       clk,
  input  logic                       en,
  input  pdv_pkg::ndc_t              ndc,
  input  logic [pdv_pkg::SIZE_W-1:0] vp_width,
  input  logic [pdv_pkg::SIZE_W-1:0] vp_height,
  output pdv_pkg::pix_t              pre
);

  logic signed [pdv_pkg::CW-1:0] nx;
  logic signed [pdv_pkg::CW-1:0] ny;
  logic signed [pdv_pkg::CW:0]   bx;
  logic signed [pdv_pkg::CW:0]   by;

  // Zero w forces ndc to the origin
  assign nx = ndc.wz ? '0 : ndc.nx;
  assign ny = ndc.wz ? '0 : ndc.ny;
  assign bx = {nx[pdv_pkg::CW-1], nx} + pdv_pkg::ONEQ;
  assign by = pdv_pkg::ONEQ - {ny[pdv_pkg::CW-1], ny};

  // Stage 1: products
  logic signed [pdv_pkg::PW-1:0] px;
  logic signed [pdv_pkg::PW-1:0] py;
  logic signed [pdv_pkg::CW-1:0] z1;
  logic signed [pdv_pkg::CW-1:0] w1;
  logic                          wz1;
  logic                          sat1;

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= pdv_pkg::PW'(bx) * pdv_pkg::PW'($signed({1'b0, vp_width}));
      py   <= pdv_pkg::PW'(by) * pdv_pkg::PW'($signed({1'b0, vp_height}));
      z1   <= ndc.wz ? '0 : ndc.nz;
      w1   <= ndc.wz ? '0 : ndc.w;
      wz1  <= ndc.wz;
      sat1 <= ndc.wz ? 1'b0 : ndc.sat;
    end
  end

  // Stage 2: halve toward zero and clamp
  pdv_pkg::clamp_t cx;
  pdv_pkg::clamp_t cy;

  assign cx = pdv_pkg::half_clamp(px);
  assign cy = pdv_pkg::half_clamp(py);

  always_ff @(posedge clk) begin
    if (en) begin
      pre.screen_x   <= cx.val;
      pre.screen_y   <= cy.val;
      pre.depth_z    <= z1;
      pre.w_out      <= w1;
      pre.w_was_zero <= wz1;
      pre.saturated  <= sat1 | cx.sat | cy.sat;
    end
  end

endmodule

[rtl/perspective_divide_viewport.sv]
// Perspective divide and viewport transform: one vertex per unstalled cycle through three divider lanes.
// Coordinates are Q16.16; the divider lanes are fully pipelined, one quotient bit per stage.
// Throughput: one vertex per cycle while the pipeline enable is high.
// The pipeline advances unless its last stage and the output register both hold stalled beats.
// Reset (synchronous, rst high) empties the pipeline and sets width 640, height 480.
`timescale 1ns / 1ps
module perspective_divide_viewport (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vtx_valid,
  output logic                           vtx_stall,
  input  pdv_pkg::vtx_t                  vtx,
  output logic                           pix_valid,
  input  logic                           pix_stall,
  output pdv_pkg::pix_t                  pix,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdv_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PIPE_LEN = 1 + pdv_pkg::DIV_LAT + 2;

  // Configuration registers
  logic [pdv_pkg::SIZE_W-1:0] vp_width;
  logic [pdv_pkg::SIZE_W-1:0] vp_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width  <= pdv_pkg::VP_WIDTH_RST;
      vp_height <= pdv_pkg::VP_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pdv_pkg::REG_VP_WIDTH:  vp_width  <= cfg_data[pdv_pkg::SIZE_W-1:0];
        pdv_pkg::REG_VP_HEIGHT: vp_height <= cfg_data[pdv_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable
  logic [PIPE_LEN-1:0] vld;
  logic                pre_valid;
  logic                en;

  assign pre_valid = vld[PIPE_LEN-1];
  assign en        = !(pre_valid && pix_valid && pix_stall);
  assign vtx_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], vtx_valid};
    end
  end

  // Input stage: magnitudes and quotient signs
  logic [pdv_pkg::CW-1:0]        ma_x, ma_y, ma_z, md;
  logic                          ng_x, ng_y, ng_z;
  logic signed [pdv_pkg::CW-1:0] w0;
  logic                          wz0;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_x <= pdv_pkg::mag(vtx.clip_x);
      ma_y <= pdv_pkg::mag(vtx.clip_y);
      ma_z <= pdv_pkg::mag(vtx.clip_z);
      md   <= pdv_pkg::mag(vtx.clip_w);
      ng_x <= vtx.clip_x[pdv_pkg::CW-1] ^ vtx.clip_w[pdv_pkg::CW-1];
      ng_y <= vtx.clip_y[pdv_pkg::CW-1] ^ vtx.clip_w[pdv_pkg::CW-1];
      ng_z <= vtx.clip_z[pdv_pkg::CW-1] ^ vtx.clip_w[pdv_pkg::CW-1];
      w0   <= vtx.clip_w;
      wz0  <= vtx.clip_w == '0;
    end
  end

  // Divider lanes
  logic signed [pdv_pkg::CW-1:0] qx, qy, qz;
  logic                          sx, sy, sz;

  pdv_div_lane u_lane_x (.clk, .en, .mag_a(ma_x), .mag_d(md), .neg(ng_x), .quot(qx), .sat(sx));
  pdv_div_lane u_lane_y (.clk, .en, .mag_a(ma_y), .mag_d(md), .neg(ng_y), .quot(qy), .sat(sy));
  pdv_div_lane u_lane_z (.clk, .en, .mag_a(ma_z), .mag_d(md), .neg(ng_z), .quot(qz), .sat(sz));

  // Side band delay matching the lanes
  logic signed [pdv_pkg::CW-1:0] w_dly  [0:pdv_pkg::DIV_LAT-1];
  logic                          wz_dly [0:pdv_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      w_dly[0]  <= w0;
      wz_dly[0] <= wz0;
      for (int i = 1; i < pdv_pkg::DIV_LAT; i++) begin
        w_dly[i]  <= w_dly[i-1];
        wz_dly[i] <= wz_dly[i-1];
      end
    end
  end

  // Merge lane results
  pdv_pkg::ndc_t ndc;

  assign ndc.nx  = qx;
  assign ndc.ny  = qy;
  assign ndc.nz  = qz;
  assign ndc.w   = w_dly[pdv_pkg::DIV_LAT-1];
  assign ndc.wz  = wz_dly[pdv_pkg::DIV_LAT-1];
  assign ndc.sat = sx | sy | sz;

  pdv_pkg::pix_t pre;

  pdv_viewport u_viewport (
    .clk,
    .en,
    .ndc,
    .vp_width,
    .vp_height,
    .pre
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || !pix_stall) begin
      pix_valid <= pre_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pix_valid || !pix_stall) begin
      pix <= pre;
    end
  end

`include "perspective_divide_viewport_macros.svh"

  `PDV_ASSERT_IMP(a_zero_w_out, pix_valid && pix.w_was_zero, pix.depth_z == '0 && pix.w_out == '0)
  `PDV_ASSERT_IMP(a_stall_only_full, vtx_stall, pre_valid && pix_valid)
  `PDV_ASSERT_IMP(a_hold_full, pre_valid && pix_valid && pix_stall, ##1 pre_valid)
  `PDV_ASSERT_AFTER_RST(a_rst_empty, !pix_valid && vld == '0)

endmodule
